// File: rtl/sem_pkg.sv
// Package for the Sobel edge magnitude block: widths, constants, opcodes and command/status types.
// No dependencies.
`default_nettype none
package sem_pkg;
  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int CfgW = 11;
  localparam int PixW = 24;
  localparam logic [CfgW-1:0] WidthReset = CfgW'(MaxWidth);
  localparam logic [16:0] SumLimit = 17'd65280;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_a;
    logic emit_b;
    logic commit;
  } sem_cmd_t;

  typedef struct packed {
    logic first_row;
    logic col_zero;
    logic col_one;
    logic row_end;
    logic flush;
    logic root_done;
  } sem_sts_t;
endpackage
`default_nettype wire

// File: rtl/sem_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface sem_if #(parameter int W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_if, sem_ctrl, sem_dp.
//
//  channel | dir | payload
//  in_     | in  | op, red_in, green_in, blue_in
//  out_    | out | red_out, green_out, blue_out, run_last, frame_end
//  cfg_    | in  | frame_width (11 bit)
//
// An item that gives no result is accepted and committed; one with a result is
// accepted, summed, passed through the bit-serial square root and sent, and a
// second result adds another root and send.
// Reset (rst_n low, synchronous) clears the window and column count, sets the
// first-row flag and the width to 1024; line stores hold garbage until written.
// Output stalls hold the sequencer; input is not taken until the item commits.
`default_nettype none
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sem_if.sink       in_ch,
  sem_if.source     out_ch,
  sem_if.sink       cfg_ch
);
  sem_cmd_t cmd;
  sem_sts_t sts;
  logic in_rdy, out_vld, out_second;
  logic [7:0] mr, mg, mb;
  logic lst, fe;

  // configuration always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = {mr, mg, mb, lst, fe};

  sem_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire (in_ch.valid && in_rdy),
    .out_fire(out_vld && out_ch.ready),
    .sts, .in_rdy, .out_vld, .out_second, .cmd
  );

  sem_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_op(in_ch.data[24]), .in_r(in_ch.data[23:16]),
    .in_g(in_ch.data[15:8]), .in_b(in_ch.data[7:0]),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data[CfgW-1:0]),
    .out_second, .sts,
    .mag_r(mr), .mag_g(mg), .mag_b(mb), .last_o(lst), .fend_o(fe)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data[0] |-> out_ch.data[1]) else $error("frame_end not last");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("overlap");
`endif
endmodule
`default_nettype wire

// File: rtl/sem_ctrl.sv
// Sequencer for the Sobel block: accept, compute and send up to two results, commit.
// Depends on sem_pkg.
`default_nettype none
module sem_ctrl
  import sem_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire logic     out_fire,
  input  sem_sts_t      sts,
  output logic          in_rdy,
  output logic          out_vld,
  output logic          out_second,
  output sem_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RDA = 3'd1, S_CA = 3'd2, S_SA = 3'd3,
                         S_CB = 3'd4, S_SB = 3'd5;
  logic [2:0] st_r, st_nxt;
  logic need_a, need_b;

  assign need_a = !sts.first_row && !sts.col_zero;
  assign need_b = !sts.first_row && sts.row_end;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    case (st_r)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) st_nxt = S_RDA;
      end
      S_RDA: begin
        if (need_a) begin
          cmd.emit_a = 1'b1; st_nxt = S_CA;
        end else if (need_b) begin
          cmd.emit_b = 1'b1; st_nxt = S_CB;
        end else begin
          cmd.commit = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_CA: begin
        cmd.step = 1'b1;
        if (sts.root_done) st_nxt = S_SA;
      end
      S_SA: begin
        if (out_fire) begin
          if (need_b) begin
            cmd.emit_b = 1'b1; st_nxt = S_CB;
          end else begin
            cmd.commit = 1'b1; st_nxt = S_IDLE;
          end
        end
      end
      S_CB: begin
        cmd.step = 1'b1;
        if (sts.root_done) st_nxt = S_SB;
      end
      S_SB: begin
        if (out_fire) begin
          cmd.commit = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  assign in_rdy = (st_r == S_IDLE);
  assign out_vld = (st_r == S_SA) || (st_r == S_SB);
  assign out_second = (st_r == S_SB);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_rdy && out_vld)) else $error("input taken while result pending");
  a_b_after: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SB) |-> ($past(st_r) == S_SB || $past(st_r) == S_CB))
    else $error("bad entry to second result");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_rdy) else $error("commit did not return to idle");
`endif
endmodule
`default_nettype wire

// File: rtl/sem_dp.sv
// Datapath: line stores, window, Sobel sums and serial rounded square roots.
// Depends on sem_pkg.
`default_nettype none
module sem_dp
  import sem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  sem_cmd_t         cmd,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_r,
  input  wire logic [7:0]  in_g,
  input  wire logic [7:0]  in_b,
  input  wire logic        cfg_we,
  input  wire logic [CfgW-1:0] cfg_data,
  input  wire logic        out_second,
  output sem_sts_t         sts,
  output logic [7:0]       mag_r,
  output logic [7:0]       mag_g,
  output logic [7:0]       mag_b,
  output logic             last_o,
  output logic             fend_o
);
  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];
  logic [PixW-1:0] up_rd_r, mid_rd_r, pix_r;
  logic [PixW-1:0] win_r [6];
  logic [ColW-1:0] col_r;
  logic            first_r, flush_r;
  logic [CfgW-1:0] width_r;
  logic [CfgW-1:0] wclamp;
  logic [PixW-1:0] lf [3];
  logic [PixW-1:0] md [3];
  logic [PixW-1:0] rt [3];
  logic [16:0] s_r [3];
  logic [7:0]  root_r [3];
  logic [3:0]  bit_r;
  logic        busy_r;
  logic        last_r, fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) width_r <= WidthReset;
    else if (cfg_we) width_r <= cfg_data;
  end

  always_comb begin
    wclamp = width_r;
    if (width_r == '0) wclamp = CfgW'(1);
    if (width_r > CfgW'(MaxWidth)) wclamp = CfgW'(MaxWidth);
  end

  assign sts.first_row = first_r;
  assign sts.col_zero  = (col_r == '0);
  assign sts.col_one   = (col_r == ColW'(1));
  assign sts.row_end   = ({1'b0, col_r} >= (wclamp - CfgW'(1)));
  assign sts.flush     = flush_r;
  assign sts.root_done = busy_r && (bit_r == '0);

  // load: read both stores at the current column, latch pixel; commit: write both stores
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      up_rd_r  <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
      pix_r    <= (in_op == OP_FLUSH) ? '0 : {in_r, in_g, in_b};
      flush_r  <= (in_op == OP_FLUSH);
    end
    if (cmd.commit) begin
      upper_mem[col_r]  <= first_r ? '0 : mid_rd_r;
      middle_mem[col_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
      col_r   <= '0;
      first_r <= 1'b1;
    end else if (cmd.commit) begin
      win_r[0] <= sts.col_zero ? '0 : win_r[3];
      win_r[1] <= sts.col_zero ? '0 : win_r[4];
      win_r[2] <= sts.col_zero ? '0 : win_r[5];
      win_r[3] <= up_rd_r;
      win_r[4] <= mid_rd_r;
      win_r[5] <= pix_r;
      if (sts.row_end) begin
        col_r   <= '0;
        first_r <= flush_r;
      end else begin
        col_r <= col_r + ColW'(1);
      end
    end
  end

  // window select for result A (centred c-1) or B (centred c)
  always_comb begin
    if (cmd.emit_b) begin
      lf[0] = sts.col_zero ? '0 : win_r[3];
      lf[1] = sts.col_zero ? '0 : win_r[4];
      lf[2] = sts.col_zero ? '0 : win_r[5];
      md[0] = up_rd_r; md[1] = mid_rd_r; md[2] = pix_r;
      rt[0] = '0; rt[1] = '0; rt[2] = '0;
    end else begin
      lf[0] = sts.col_one ? '0 : win_r[0];
      lf[1] = sts.col_one ? '0 : win_r[1];
      lf[2] = sts.col_one ? '0 : win_r[2];
      md[0] = win_r[3]; md[1] = win_r[4]; md[2] = win_r[5];
      rt[0] = up_rd_r; rt[1] = mid_rd_r; rt[2] = pix_r;
    end
  end

  function automatic logic [16:0] sumsq(input logic [PixW-1:0] l0, l1, l2,
                                        m0, m2, r0, r1, r2, input int sh);
    logic signed [11:0] gx, gy;
    logic signed [21:0] gxw, gyw;
    logic [21:0] sq;
    begin
      gx = $signed({4'b0, r0[sh+:8]}) - $signed({4'b0, l0[sh+:8]})
         + 12'sd2 * ($signed({4'b0, r1[sh+:8]}) - $signed({4'b0, l1[sh+:8]}))
         + $signed({4'b0, r2[sh+:8]}) - $signed({4'b0, l2[sh+:8]});
      gy = $signed({4'b0, l2[sh+:8]}) + 12'sd2 * $signed({4'b0, m2[sh+:8]})
         + $signed({4'b0, r2[sh+:8]}) - $signed({4'b0, l0[sh+:8]})
         - 12'sd2 * $signed({4'b0, m0[sh+:8]}) - $signed({4'b0, r0[sh+:8]});
      // widen before squaring so the products keep every bit
      gxw = 22'(gx);
      gyw = 22'(gy);
      sq = $unsigned(gxw * gxw + gyw * gyw);
      sumsq = (sq > 22'(SumLimit)) ? 17'h1FFFF : sq[16:0];
    end
  endfunction

  // bit-serial root: one bit per cycle for all three channels, then round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else if (cmd.emit_a || cmd.emit_b) begin
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= sumsq(lf[0], lf[1], lf[2], md[0], md[2], rt[0], rt[1], rt[2],
                        16 - 8 * k);
        root_r[k] <= '0;
      end
      busy_r <= 1'b1;
      bit_r  <= 4'd8;
      last_r <= cmd.emit_b || !sts.row_end || sts.first_row;
      fend_r <= cmd.emit_b && flush_r;
    end else if (cmd.step && busy_r) begin
      if (bit_r != '0) begin
        for (int k = 0; k < 3; k++) begin
          logic [7:0]  t;
          logic [15:0] tsq;
          t = root_r[k] | (8'd1 << (bit_r - 4'd1));
          tsq = {8'b0, t} * {8'b0, t};
          if (s_r[k] != 17'h1FFFF && tsq <= s_r[k][15:0] || s_r[k][16] &&
              s_r[k] != 17'h1FFFF)
            root_r[k] <= t;
        end
        bit_r <= bit_r - 4'd1;
      end else begin
        busy_r <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (s_r[k] == 17'h1FFFF) root_r[k] <= 8'hFF;
          else if (s_r[k] > 17'({9'b0, root_r[k]} * {9'b0, root_r[k]})
                            + 17'(root_r[k]) && root_r[k] != 8'hFF)
            root_r[k] <= root_r[k] + 8'd1;
        end
      end
    end
  end

  assign mag_r = root_r[0];
  assign mag_g = root_r[1];
  assign mag_b = root_r[2];
  assign last_o = out_second ? 1'b1 : last_r;
  assign fend_o = fend_r;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !sts.row_end |=> col_r != '0) else $error("column wrap");
  a_rowend_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && sts.row_end |=> col_r == '0) else $error("row end lost");
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_a || cmd.emit_b) |=> busy_r) else $error("root not started");
`endif
endmodule
`default_nettype wire

// File: dv/sobel_edge_magnitude_rgb_tb.sv
// Self-checking testbench for sobel_edge_magnitude_rgb: random and directed RGB frames.
// Depends on sem_pkg, sem_if and sobel_edge_magnitude_rgb; predicts every result beat and compares it field by field.
`default_nettype none
module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InW = 25;   // {op, red, green, blue}
  localparam int OutW = 26;  // {red, green, blue, run_last, frame_end}
  localparam int CycleLimit = 1500000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
    logic       frame_end;
  } edge_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sem_if #(.W(InW))  in_ch  (.clk(clk));
  sem_if #(.W(OutW)) out_ch (.clk(clk));
  sem_if #(.W(CfgW)) cfg_ch (.clk(clk));

  sobel_edge_magnitude_rgb DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Stimulus and expected results
  pixel_beat_t pixel_queue[$];
  edge_beat_t  edge_expect[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  // Predictor state: shadow copy of the line stores, window and row tracking
  logic [23:0] upper_line[MaxWidth];
  logic [23:0] middle_line[MaxWidth];
  logic [23:0] win_prev[3];   // column c-2, rows upper/middle/lower
  logic [23:0] win_last[3];   // column c-1
  int          col_pos;
  bit          top_row;
  logic [CfgW-1:0] width_reg;

  function automatic logic [7:0] rounded_root(int gx, int gy);
    int unsigned s, r, t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s > 65280) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    if (s > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Sobel over three columns (left, mid, right), rows 0..2 each
  function automatic edge_beat_t sobel_rgb(logic [23:0] lf[3], logic [23:0] md[3],
                                          logic [23:0] rt[3]);
    edge_beat_t res;
    logic [7:0] mag[3];
    int gx, gy, sh;
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      gx = (int'((rt[0] >> sh) & 8'hFF) - int'((lf[0] >> sh) & 8'hFF))
         + 2 * (int'((rt[1] >> sh) & 8'hFF) - int'((lf[1] >> sh) & 8'hFF))
         + (int'((rt[2] >> sh) & 8'hFF) - int'((lf[2] >> sh) & 8'hFF));
      gy = (int'((lf[2] >> sh) & 8'hFF) + 2 * int'((md[2] >> sh) & 8'hFF)
            + int'((rt[2] >> sh) & 8'hFF))
         - (int'((lf[0] >> sh) & 8'hFF) + 2 * int'((md[0] >> sh) & 8'hFF)
            + int'((rt[0] >> sh) & 8'hFF));
      mag[k] = rounded_root(gx, gy);
    end
    res = '0;
    res.red = mag[0];
    res.green = mag[1];
    res.blue = mag[2];
    return res;
  endfunction

  // Advance the shadow state by one accepted pixel beat, queue its results
  task automatic predict_edges(pixel_beat_t pb);
    logic [23:0] cur[3];
    logic [23:0] zero3[3];
    logic [23:0] lf_sel[3];
    edge_beat_t  res;
    edge_beat_t  made[$];
    int          w;
    int          c;
    bit          row_end;
    bit          flush;
    w = (width_reg < 1) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : int'(width_reg));
    c = (col_pos >= MaxWidth) ? MaxWidth - 1 : col_pos;
    row_end = (c >= w - 1);
    flush = (pb.op == OP_FLUSH);
    zero3 = '{24'd0, 24'd0, 24'd0};
    cur[0] = upper_line[c];
    cur[1] = middle_line[c];
    cur[2] = flush ? 24'd0 : {pb.red, pb.green, pb.blue};
    if (!top_row) begin
      if (c >= 1) begin
        if (c == 1) lf_sel = zero3;
        else lf_sel = win_prev;
        res = sobel_rgb(lf_sel, win_last, cur);
        made.push_back(res);
      end
      if (row_end) begin
        if (c == 0) lf_sel = zero3;
        else lf_sel = win_last;
        res = sobel_rgb(lf_sel, cur, zero3);
        res.frame_end = flush;
        made.push_back(res);
      end
      if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
      foreach (made[i]) edge_expect.push_back(made[i]);
    end
    upper_line[c] = top_row ? 24'd0 : middle_line[c];
    middle_line[c] = cur[2];
    win_prev = win_last;
    win_last = cur;
    if (c == 0) win_prev = zero3;
    if (row_end) begin
      col_pos = 0;
      top_row = flush;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Driver: hold a beat until accepted, insert random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_edges(pixel_beat_t'(in_ch.data));
        sent_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pixel_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare every result beat
  always @(posedge clk) begin
    edge_beat_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = edge_beat_t'(out_ch.data);
        if (edge_expect.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          error_count++;
        end else begin
          want = edge_expect.pop_front();
          if (got.red !== want.red)
            $display("%0t: red_out expected %0d actual %0d", $time, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: green_out expected %0d actual %0d", $time, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: blue_out expected %0d actual %0d", $time, want.blue, got.blue);
          if (got.run_last !== want.run_last)
            $display("%0t: run_last expected %0d actual %0d", $time, want.run_last,
                     got.run_last);
          if (got.frame_end !== want.frame_end)
            $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
                     got.frame_end);
          if (got !== want) error_count++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic pixel_beat_t rand_pixel();
    pixel_beat_t pb;
    pb.op = OP_PIXEL;
    if ($urandom_range(3) == 0) begin
      // extreme channels make the sharpest edges and hit the clamp
      pb.red = $urandom_range(1) ? 8'hFF : 8'h00;
      pb.green = $urandom_range(1) ? 8'hFF : 8'h00;
      pb.blue = $urandom_range(1) ? 8'hFF : 8'h00;
    end else begin
      pb.red = 8'($urandom_range(255));
      pb.green = 8'($urandom_range(255));
      pb.blue = 8'($urandom_range(255));
    end
    return pb;
  endfunction

  // Queue one frame: rows of pixels with some stray flush beats, then complete
  // the row and drain with a full flush row so the block ends at a frame start
  task automatic queue_frame(int w, int rows, int flush_pct);
    pixel_beat_t pb;
    int g;
    g = 0;
    for (int i = 0; i < w * rows; i++) begin
      pb = rand_pixel();
      if ($urandom_range(99) < flush_pct) begin
        pb.op = OP_FLUSH;  // payload should be ignored
      end
      pixel_queue.push_back(pb);
      g = (g + 1 == w) ? 0 : g + 1;
    end
    while (g != 0) begin
      pixel_queue.push_back(rand_pixel());
      g = (g + 1 == w) ? 0 : g + 1;
    end
    for (int i = 0; i < w; i++) begin
      pb = rand_pixel();
      pb.op = OP_FLUSH;
      pixel_queue.push_back(pb);
    end
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_ch.valid || edge_expect.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write frame_width; block must be idle
  task automatic write_width(logic [CfgW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    width_reg = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 65; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 65; end
      default: begin send_gap_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin
    pixel_beat_t pb;
    int w;
    int mode;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    win_prev = '{24'd0, 24'd0, 24'd0};
    win_last = '{24'd0, 24'd0, 24'd0};
    col_pos = 0;
    top_row = 1'b1;
    width_reg = WidthReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: width 0 acts as one column; all-0 / all-255 extremes
    write_width(11'd0);
    pixel_queue.push_back('{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back('{OP_PIXEL, 8'h00, 8'h00, 8'h00});
    pixel_queue.push_back('{OP_PIXEL, 8'hFF, 8'h00, 8'hFF});
    pixel_queue.push_back('{OP_FLUSH, 8'hFF, 8'hFF, 8'hFF});
    wait_idle();

    // Directed: width 3, checkerboard, flush mid-row, a row ending on a flush
    write_width(11'd3);
    for (int i = 0; i < 9; i++) begin
      pb.op = OP_PIXEL;
      pb.red = (i % 2) ? 8'hFF : 8'h00;
      pb.green = (i % 2) ? 8'h00 : 8'hFF;
      pb.blue = (i % 3 == 0) ? 8'hFF : 8'h5A;
      pixel_queue.push_back(pb);
    end
    pixel_queue.push_back('{OP_FLUSH, 8'hAA, 8'h55, 8'hFF});
    pixel_queue.push_back('{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back('{OP_FLUSH, 8'h00, 8'h00, 8'h00});
    queue_frame(3, 2, 0);
    wait_idle();

    // Directed: width above the maximum acts as the maximum. One full top row,
    // two pixels into the next, then narrow to three so the next pixel ends
    // the row early and a short flush row closes the frame.
    write_width(11'h7FF);
    for (int i = 0; i < MaxWidth + 2; i++) pixel_queue.push_back(rand_pixel());
    wait_idle();
    write_width(11'd3);
    pixel_queue.push_back(rand_pixel());
    for (int i = 0; i < 3; i++) begin
      pb = rand_pixel();
      pb.op = OP_FLUSH;
      pixel_queue.push_back(pb);
    end
    wait_idle();
    write_width(11'd1);
    queue_frame(1, 4, 25);
    wait_idle();

    // Random: small widths, idling modes rotate per phase
    mode = 0;
    while (sent_count < 1150 || mode != 0) begin
      set_idling(mode);
      mode = (mode + 1) % 4;
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
      write_width(11'(w));
      for (int f = 0; f < 2; f++) begin
        queue_frame(w, $urandom_range(1, 6), $urandom_range(1) ? 0 : 10);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
